@@ rtl/plt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the palette light color transform.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int ColorWidth  = 8;
   localparam int LaneWidth   = 16;
   localparam int PackedWidth = 48;
   localparam int FadeWidth   = 16;
   localparam int WordWidth   = 16;
   localparam int SlotWidth   = 2;
   localparam int CsrIdxWidth = 3;
   localparam int DivSteps    = 28;
   localparam int DivCntWidth = 5;

   localparam logic [CsrIdxWidth-1:0] CsrAmbientAdd   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrAmbientScale = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLightColor   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrFadeAmount   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrGrayEnable   = 3'd4;

   localparam logic [FadeWidth-1:0] FadeReset = 16'd4096;

   typedef struct packed {
      logic [ColorWidth-1:0] red;
      logic [ColorWidth-1:0] green;
      logic [ColorWidth-1:0] blue;
      logic                  gray;
   } item_type;

   // Signed Q4.12 lane of a packed triple: 0 red, 1 green, 2 blue.
   function automatic logic signed [LaneWidth-1:0] lane(
      input logic [PackedWidth-1:0] packed_val,
      input logic [1:0]             ch
   );
      logic signed [LaneWidth-1:0] res;
      case (ch)
         2'd0:    res = $signed(packed_val[47:32]);
         2'd1:    res = $signed(packed_val[31:16]);
         default: res = $signed(packed_val[15:0]);
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

@@ rtl/plt_scale_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_scale_div
// Serial restoring divider for the lit scale: fade * 4096 / (4096 + max light),
// one quotient bit per cycle, truncated toward zero and saturated to Q4.12.
// ----------------------------------------------------------------------------
module plt_scale_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [plt_pkg::FadeWidth-1:0]         fade,
   input  wire logic signed [plt_pkg::LaneWidth-1:0]  light_max,
   output logic                                       busy,
   output logic signed [plt_pkg::LaneWidth-1:0]       lit_scale
);

   localparam int NumWidth = plt_pkg::FadeWidth + 12;

   logic                         busy_ff, busy_in;
   logic [plt_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic                         zero_ff, zero_in;
   logic                         fade_nz_ff, fade_nz_in;
   logic [16:0]                  dmag_ff, dmag_in;
   logic [16:0]                  rem_ff, rem_in;
   logic [NumWidth-1:0]          num_ff, num_in;
   logic signed [plt_pkg::LaneWidth-1:0] ls_ff, ls_in;

   logic signed [16:0]           d;
   logic [17:0]                  trial;
   logic                         qbit;

   always_comb begin
      d       = 17'(light_max) + 17'sd4096;
      trial   = {rem_ff, num_ff[NumWidth-1]};
      qbit    = trial >= {1'b0, dmag_ff};
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      fade_nz_in = fade_nz_ff;
      dmag_in    = dmag_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      ls_in      = ls_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = plt_pkg::DivCntWidth'(plt_pkg::DivSteps);
         neg_in     = d[16];
         zero_in    = d == 17'sd0;
         fade_nz_in = fade != '0;
         dmag_in    = d[16] ? 17'(-d) : 17'(d);
         rem_in     = '0;
         num_in     = {fade, 12'd0};
      end else if (busy_ff && cnt_ff != '0) begin
         rem_in = qbit ? 17'(trial - {1'b0, dmag_ff}) : trial[16:0];
         num_in = {num_ff[NumWidth-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         if (zero_ff) begin
            ls_in = fade_nz_ff ? 16'sd32767 : 16'sd0;
         end else if (!neg_ff) begin
            ls_in = (num_ff > NumWidth'(32767)) ? 16'sd32767 : $signed(num_ff[15:0]);
         end else begin
            ls_in = (num_ff > NumWidth'(32768)) ? $signed(16'h8000)
                                                : $signed(16'(-num_ff[15:0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      fade_nz_ff <= fade_nz_in;
      dmag_ff    <= dmag_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      ls_ff      <= ls_in;
   end

   assign busy      = busy_ff;
   assign lit_scale = ls_ff;

endmodule
`default_nettype wire

@@ rtl/plt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_front
// Accepts input items, flags those to be turned gray and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module plt_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [plt_pkg::ColorWidth-1:0]  req_red_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]  req_green_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]  req_blue_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]  req_palette_index,
   input  wire logic                            gray_enable,
   input  wire logic                            hold,
   output logic                                 item_valid,
   output plt_pkg::item_type                    item,
   input  wire logic                            item_pop
);

   // index mod 12 through a reciprocal multiply, exact for 8-bit indexes
   localparam logic [7:0]  ModBase   = 8'd12;
   localparam logic [15:0] ModRecip  = 16'd171;
   localparam int          ModShift  = 11;
   localparam logic [7:0]  KeepIndex = 8'd4;

   plt_pkg::item_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic        accept;
   logic        do_pop;
   logic [15:0] recip_prod;
   logic [4:0]  quot;
   logic [7:0]  remainder;
   plt_pkg::item_type new_item;

   always_comb begin
      recip_prod = {8'd0, req_palette_index} * ModRecip;
      quot       = recip_prod[15:ModShift];
      remainder  = req_palette_index - 8'({3'd0, quot} * ModBase);
      new_item.red   = req_red_in;
      new_item.green = req_green_in;
      new_item.blue  = req_blue_in;
      new_item.gray  = gray_enable && remainder != KeepIndex;
   end

   assign req_full   = count_ff == 2'd2 || hold;
   assign accept     = req_push && !req_full;
   assign item_valid = count_ff != 2'd0;
   assign do_pop     = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/plt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_back
// Runs the three channels of an item through a shared multiply pipeline,
// packs the ambient and lit words and sends four results per item.
// ----------------------------------------------------------------------------
module plt_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  item_valid,
   input  wire plt_pkg::item_type                     item,
   output logic                                       item_pop,
   input  wire logic [plt_pkg::PackedWidth-1:0]       ambient_add,
   input  wire logic [plt_pkg::PackedWidth-1:0]       ambient_scale,
   input  wire logic [plt_pkg::PackedWidth-1:0]       light_color,
   input  wire logic [plt_pkg::FadeWidth-1:0]         fade,
   input  wire logic signed [plt_pkg::LaneWidth-1:0]  lit_scale,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [plt_pkg::WordWidth-1:0]              rsp_pixel_word,
   output logic [plt_pkg::SlotWidth-1:0]              rsp_slot,
   output logic                                       rsp_is_last
);

   localparam int PairDepth = 4;
   localparam logic signed [57:0] TopAmb = 58'sd255 <<< 36;
   localparam logic signed [40:0] TopLit = 41'sd255 <<< 24;

   // issue
   logic [1:0] ch_ff, ch_in;
   logic [2:0] credit_ff, credit_in;
   logic       issue, start_item, release_pair;

   // stage 1
   logic              s1_valid_ff;
   logic [1:0]        s1_ch_ff;
   logic              s1_gray_ff;
   logic signed [24:0] s1_sum_a_ff, s1_sum_a_in;
   logic signed [24:0] s1_sum_l_ff, s1_sum_l_in;
   logic signed [32:0] s1_ascale_ff, s1_ascale_in;

   // stage 2
   logic              s2_valid_ff;
   logic [1:0]        s2_ch_ff;
   logic              s2_gray_ff;
   logic signed [57:0] s2_n_a_ff, s2_n_a_in;
   logic signed [40:0] s2_n_l_ff, s2_n_l_in;

   // stage 3
   logic [7:0] chan_a_ff [3];
   logic [7:0] chan_l_ff [3];
   logic [7:0] sat_a, sat_l;
   logic       done_ff, done_gray_ff;

   // result pairs
   logic [plt_pkg::WordWidth-1:0] pair_w0_ff [PairDepth];
   logic [plt_pkg::WordWidth-1:0] pair_w1_ff [PairDepth];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff, count_in;
   logic [plt_pkg::SlotWidth-1:0] slot_ff, slot_in;
   logic [plt_pkg::WordWidth-1:0] word_a, word_l;
   logic       out_pop;

   logic [7:0]         color;
   logic signed [24:0] add_a, add_l;
   logic signed [15:0] amb_scale;

   function automatic logic [plt_pkg::WordWidth-1:0] pack_word(
      input logic [7:0] r,
      input logic [7:0] g,
      input logic [7:0] b,
      input logic       gray
   );
      logic [15:0] y;
      logic [7:0]  rr, gg, bb;
      y  = 16'(16'd54 * r) + 16'(16'd182 * g) + 16'(16'd18 * b);
      rr = gray ? y[15:8] : r;
      gg = gray ? y[15:8] : g;
      bb = gray ? y[15:8] : b;
      return {rr[7:3], gg[7:3], bb[7:3], 1'b1};
   endfunction

   assign issue        = item_valid && (ch_ff != 2'd0 || credit_ff < 3'(PairDepth));
   assign start_item   = issue && ch_ff == 2'd0;
   assign item_pop     = issue && ch_ff == 2'd2;
   assign out_pop      = rsp_pop && !rsp_empty;
   assign release_pair = out_pop && slot_ff == 2'd3;

   always_comb begin
      case (ch_ff)
         2'd0:    color = item.red;
         2'd1:    color = item.green;
         default: color = item.blue;
      endcase
      add_a     = 25'(plt_pkg::lane(ambient_add, ch_ff));
      add_l     = 25'(plt_pkg::lane(light_color, ch_ff));
      amb_scale = plt_pkg::lane(ambient_scale, ch_ff);
      s1_sum_a_in  = $signed({5'd0, color, 12'd0}) + (add_a <<< 8) - add_a;
      s1_sum_l_in  = $signed({5'd0, color, 12'd0}) + (add_l <<< 8) - add_l;
      s1_ascale_in = 33'(amb_scale) * 33'($signed({1'b0, fade}));
      s2_n_a_in    = 58'(s1_sum_a_ff) * 58'(s1_ascale_ff);
      s2_n_l_in    = 41'(s1_sum_l_ff) * 41'(lit_scale);

      if (s2_n_a_ff > TopAmb) begin
         sat_a = 8'd255;
      end else if (s2_n_a_ff[57]) begin
         sat_a = 8'd0;
      end else begin
         sat_a = s2_n_a_ff[43:36];
      end
      if (s2_n_l_ff > TopLit) begin
         sat_l = 8'd255;
      end else if (s2_n_l_ff[40]) begin
         sat_l = 8'd0;
      end else begin
         sat_l = s2_n_l_ff[31:24];
      end

      word_a = pack_word(chan_a_ff[0], chan_a_ff[1], chan_a_ff[2], done_gray_ff);
      word_l = pack_word(chan_l_ff[0], chan_l_ff[1], chan_l_ff[2], done_gray_ff);

      ch_in     = issue ? ((ch_ff == 2'd2) ? 2'd0 : ch_ff + 2'd1) : ch_ff;
      credit_in = credit_ff + 3'(start_item) - 3'(release_pair);
      count_in  = count_ff + 3'(done_ff) - 3'(release_pair);
      slot_in   = out_pop ? slot_ff + 2'd1 : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff       <= '0;
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         slot_ff     <= '0;
      end else begin
         ch_ff       <= ch_in;
         credit_ff   <= credit_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_ch_ff == 2'd2;
         wr_ptr_ff   <= done_ff ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
         rd_ptr_ff   <= release_pair ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
         count_ff    <= count_in;
         slot_ff     <= slot_in;
      end
      s1_ch_ff     <= ch_ff;
      s1_gray_ff   <= item.gray;
      s1_sum_a_ff  <= s1_sum_a_in;
      s1_sum_l_ff  <= s1_sum_l_in;
      s1_ascale_ff <= s1_ascale_in;
      s2_ch_ff     <= s1_ch_ff;
      s2_gray_ff   <= s1_gray_ff;
      s2_n_a_ff    <= s2_n_a_in;
      s2_n_l_ff    <= s2_n_l_in;
      done_gray_ff <= s2_gray_ff;
      if (s2_valid_ff) begin
         chan_a_ff[s2_ch_ff] <= sat_a;
         chan_l_ff[s2_ch_ff] <= sat_l;
      end
      if (done_ff) begin
         pair_w0_ff[wr_ptr_ff] <= word_a;
         pair_w1_ff[wr_ptr_ff] <= word_l;
      end
   end

   assign rsp_empty      = count_ff == 3'd0;
   assign rsp_pixel_word = (slot_ff == 2'd0) ? pair_w0_ff[rd_ptr_ff] : pair_w1_ff[rd_ptr_ff];
   assign rsp_slot       = slot_ff;
   assign rsp_is_last    = slot_ff == 2'd3;

endmodule
`default_nettype wire

@@ rtl/palette_light_color_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_light_color_transform
// Turns one RGB palette color into an ambient RGBA5551 word and three lit
// copies, with optional grayscale.
// ----------------------------------------------------------------------------
// Each accepted item yields four results (slot 0 ambient, slots 1 to 3 lit),
// so the sustained item rate is set by the single result port; the three
// color channels share one multiply pipeline and issue one after another.
// After reset and after every write to light_color or fade_amount, req_full
// stays high while a serial divider, one bit per cycle, forms the lit scale.
module palette_light_color_transform (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [plt_pkg::ColorWidth-1:0]    req_red_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]    req_green_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]    req_blue_in,
   input  wire logic [plt_pkg::ColorWidth-1:0]    req_palette_index,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [plt_pkg::WordWidth-1:0]          rsp_pixel_word,
   output logic [plt_pkg::SlotWidth-1:0]          rsp_slot,
   output logic                                   rsp_is_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [plt_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [plt_pkg::PackedWidth-1:0]   csr_data
);

   logic [plt_pkg::PackedWidth-1:0] ambient_add_ff, ambient_add_in;
   logic [plt_pkg::PackedWidth-1:0] ambient_scale_ff, ambient_scale_in;
   logic [plt_pkg::PackedWidth-1:0] light_color_ff, light_color_in;
   logic [plt_pkg::FadeWidth-1:0]   fade_amount_ff, fade_amount_in;
   logic                            gray_enable_ff, gray_enable_in;
   logic                            init_ff;

   logic csr_write;
   logic div_start;
   logic div_busy;
   logic hold;
   logic signed [plt_pkg::LaneWidth-1:0] lane_r, lane_g, lane_b, light_max;
   logic signed [plt_pkg::LaneWidth-1:0] lit_scale;

   logic              item_valid;
   logic              item_pop;
   plt_pkg::item_type item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      ambient_add_in   = ambient_add_ff;
      ambient_scale_in = ambient_scale_ff;
      light_color_in   = light_color_ff;
      fade_amount_in   = fade_amount_ff;
      gray_enable_in   = gray_enable_ff;
      div_start        = init_ff;
      if (csr_write) begin
         unique case (csr_index)
            plt_pkg::CsrAmbientAdd:   ambient_add_in   = csr_data;
            plt_pkg::CsrAmbientScale: ambient_scale_in = csr_data;
            plt_pkg::CsrLightColor:   light_color_in   = csr_data;
            plt_pkg::CsrFadeAmount:   fade_amount_in   = csr_data[plt_pkg::FadeWidth-1:0];
            plt_pkg::CsrGrayEnable:   gray_enable_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_add_ff   <= '0;
         ambient_scale_ff <= '0;
         light_color_ff   <= '0;
         fade_amount_ff   <= plt_pkg::FadeReset;
         gray_enable_ff   <= 1'b0;
         init_ff          <= 1'b1;
      end else begin
         ambient_add_ff   <= ambient_add_in;
         ambient_scale_ff <= ambient_scale_in;
         light_color_ff   <= light_color_in;
         fade_amount_ff   <= fade_amount_in;
         gray_enable_ff   <= gray_enable_in;
         // restart the divider in the cycle after a scale-related write
         init_ff          <= csr_write && (csr_index == plt_pkg::CsrLightColor ||
                                           csr_index == plt_pkg::CsrFadeAmount);
      end
   end

   always_comb begin
      lane_r    = plt_pkg::lane(light_color_ff, 2'd0);
      lane_g    = plt_pkg::lane(light_color_ff, 2'd1);
      lane_b    = plt_pkg::lane(light_color_ff, 2'd2);
      light_max = lane_r;
      if (lane_g > light_max) begin
         light_max = lane_g;
      end
      if (lane_b > light_max) begin
         light_max = lane_b;
      end
   end

   assign hold = div_busy || div_start || csr_valid;

   plt_scale_div u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .fade      (fade_amount_ff),
      .light_max (light_max),
      .busy      (div_busy),
      .lit_scale (lit_scale)
   );

   plt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_palette_index (req_palette_index),
      .gray_enable       (gray_enable_ff),
      .hold              (hold),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   plt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .ambient_add    (ambient_add_ff),
      .ambient_scale  (ambient_scale_ff),
      .light_color    (light_color_ff),
      .fade           (fade_amount_ff),
      .lit_scale      (lit_scale),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_slot       (rsp_slot),
      .rsp_is_last    (rsp_is_last)
   );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for palette_light_color_transform: random and directed
// palette colors go in through the request queue, every palette word that
// comes out is checked against a local fixed-point model of the block, and
// the control registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CycleLimit     = 200000;
   localparam int HoldCycles     = 300;
   localparam int PhaseItems     = 58;
   localparam int RandomPhases   = 8;
   localparam int MaxReports     = 10;
   localparam int ResultsPerItem = 4;
   localparam int Unity          = 4096;
   localparam int ColorMax       = 255;
   localparam int AmbientFrac    = 24;
   localparam int LitFrac        = 12;
   localparam int GrayRedWeight   = 54;
   localparam int GrayGreenWeight = 182;
   localparam int GrayBlueWeight  = 18;
   localparam int KeepPeriod     = 12;
   localparam int KeepPhase      = 4;
   localparam longint LaneMax    = 32767;
   localparam longint LaneMin    = -32768;
   localparam logic [plt_pkg::SlotWidth-1:0]   SlotLastLit    = 2'd3;
   localparam logic [plt_pkg::CsrIdxWidth-1:0] CsrFirstUnused = 3'd5;
   localparam logic [plt_pkg::CsrIdxWidth-1:0] CsrLastUnused  = 3'd7;

   typedef struct packed {
      logic [plt_pkg::ColorWidth-1:0] red;
      logic [plt_pkg::ColorWidth-1:0] green;
      logic [plt_pkg::ColorWidth-1:0] blue;
      logic [plt_pkg::ColorWidth-1:0] index;
   } palette_color_type;

   typedef struct packed {
      logic [plt_pkg::WordWidth-1:0] word;
      logic [plt_pkg::SlotWidth-1:0] slot;
      logic                          last;
   } palette_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [plt_pkg::ColorWidth-1:0]  req_red_in = '0;
   logic [plt_pkg::ColorWidth-1:0]  req_green_in = '0;
   logic [plt_pkg::ColorWidth-1:0]  req_blue_in = '0;
   logic [plt_pkg::ColorWidth-1:0]  req_palette_index = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [plt_pkg::WordWidth-1:0]   rsp_pixel_word;
   logic [plt_pkg::SlotWidth-1:0]   rsp_slot;
   logic                            rsp_is_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [plt_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [plt_pkg::PackedWidth-1:0] csr_data = '0;

   // local copy of the register file
   logic [plt_pkg::PackedWidth-1:0] ambient_add_q = '0;
   logic [plt_pkg::PackedWidth-1:0] ambient_scale_q = '0;
   logic [plt_pkg::PackedWidth-1:0] light_color_q = '0;
   logic [plt_pkg::FadeWidth-1:0]   fade_q = plt_pkg::FadeReset;
   logic                            gray_q = 1'b0;

   palette_color_type color_items[$];
   palette_word_type  words_due[$];
   int unsigned    offered_n = 0;
   int unsigned    accepted_n = 0;
   int unsigned    mismatches = 0;
   int unsigned    cycle_n = 0;
   int             sender_idle_pct = 0;
   int             rsp_stall_pct = 0;
   logic           hold_arm = 1'b0;
   logic           rsp_hold = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   palette_light_color_transform i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_palette_index (req_palette_index),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_word    (rsp_pixel_word),
      .rsp_slot          (rsp_slot),
      .rsp_is_last       (rsp_is_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // signed Q4.12 lane: 0 red 47:32, 1 green 31:16, 2 blue 15:0
   function automatic longint lane_value(logic [plt_pkg::PackedWidth-1:0] p, int ch);
      logic signed [plt_pkg::LaneWidth-1:0] v;
      v = p[plt_pkg::PackedWidth-1-plt_pkg::LaneWidth*ch -: plt_pkg::LaneWidth];
      return v;
   endfunction

   // (c/255 + add) * scale, saturated, evaluated exactly in integers
   function automatic logic [plt_pkg::ColorWidth-1:0] shade(
      logic [plt_pkg::ColorWidth-1:0] c, longint add, longint scale, int frac);
      longint n;
      longint top;
      int     sh;
      sh  = 12 + frac;
      n   = (longint'(c) * Unity + ColorMax * add) * scale;
      top = longint'(ColorMax) <<< sh;
      if (n > top) return plt_pkg::ColorWidth'(ColorMax);
      if (n < 0) return '0;
      return plt_pkg::ColorWidth'(n >>> sh);
   endfunction

   function automatic logic [plt_pkg::WordWidth-1:0] pack_word(
      logic [plt_pkg::ColorWidth-1:0] r, g, b, logic [plt_pkg::ColorWidth-1:0] index);
      int y;
      if (gray_q && (index % KeepPeriod) != KeepPhase) begin
         y = (GrayRedWeight * r + GrayGreenWeight * g + GrayBlueWeight * b) >> 8;
         r = plt_pkg::ColorWidth'(y);
         g = plt_pkg::ColorWidth'(y);
         b = plt_pkg::ColorWidth'(y);
      end
      return {r[7:3], g[7:3], b[7:3], 1'b1};
   endfunction

   function automatic void predict_palette_words(palette_color_type c);
      logic [plt_pkg::ColorWidth-1:0] src [3];
      logic [plt_pkg::ColorWidth-1:0] amb [3];
      logic [plt_pkg::ColorWidth-1:0] lit [3];
      longint                brightest;
      longint                divisor;
      longint                lit_scale;
      palette_word_type      w;
      src[0] = c.red;
      src[1] = c.green;
      src[2] = c.blue;
      brightest = lane_value(light_color_q, 0);
      for (int ch = 1; ch < 3; ch++) begin
         if (lane_value(light_color_q, ch) > brightest) brightest = lane_value(light_color_q, ch);
      end
      divisor = Unity + brightest;
      if (divisor == 0) begin
         lit_scale = (fade_q != 0) ? LaneMax : 0;
      end else begin
         lit_scale = (longint'(fade_q) * Unity) / divisor;
         if (lit_scale > LaneMax) lit_scale = LaneMax;
         if (lit_scale < LaneMin) lit_scale = LaneMin;
      end
      for (int ch = 0; ch < 3; ch++) begin
         amb[ch] = shade(src[ch], lane_value(ambient_add_q, ch),
                         lane_value(ambient_scale_q, ch) * longint'(fade_q), AmbientFrac);
         lit[ch] = shade(src[ch], lane_value(light_color_q, ch), lit_scale, LitFrac);
      end
      for (int k = 0; k < ResultsPerItem; k++) begin
         w.slot = plt_pkg::SlotWidth'(k);
         w.word = (k == 0) ? pack_word(amb[0], amb[1], amb[2], c.index)
                           : pack_word(lit[0], lit[1], lit[2], c.index);
         w.last = (w.slot == SlotLastLit);
         words_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // monitor: checks results, predicts on accepted items, tracks register writes
   always @(posedge clock) begin
      palette_word_type  got;
      palette_word_type  want;
      palette_color_type taken;
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            got.word = rsp_pixel_word;
            got.slot = rsp_slot;
            got.last = rsp_is_last;
            if (words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("unexpected result: word %h slot %0d last %b",
                           got.word, got.slot, got.last);
            end else begin
               want = words_due.pop_front();
               if (got.word !== want.word || got.slot !== want.slot ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MaxReports)
                     $display("mismatch: expected word %h slot %0d last %b, got %h %0d %b",
                              want.word, want.slot, want.last,
                              got.word, got.slot, got.last);
               end
            end
         end
         if (req_push && !req_full) begin
            taken.red   = req_red_in;
            taken.green = req_green_in;
            taken.blue  = req_blue_in;
            taken.index = req_palette_index;
            predict_palette_words(taken);
            accepted_n++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               plt_pkg::CsrAmbientAdd:   ambient_add_q = csr_data;
               plt_pkg::CsrAmbientScale: ambient_scale_q = csr_data;
               plt_pkg::CsrLightColor:   light_color_q = csr_data;
               plt_pkg::CsrFadeAmount:   fade_q = csr_data[plt_pkg::FadeWidth-1:0];
               plt_pkg::CsrGrayEnable:   gray_q = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // driver: holds an item until it is taken
   always @(negedge clock) begin
      palette_color_type next_color;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || accepted_n == offered_n) begin
         if (color_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_color = color_items.pop_front();
            req_red_in        <= next_color.red;
            req_green_in      <= next_color.green;
            req_blue_in       <= next_color.blue;
            req_palette_index <= next_color.index;
            req_push          <= 1'b1;
            offered_n++;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_hold) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off
   initial begin
      wait (hold_arm);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic write_csr(logic [plt_pkg::CsrIdxWidth-1:0] index,
                            logic [plt_pkg::PackedWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_config(logic [plt_pkg::PackedWidth-1:0] add, scale, light,
                               logic [plt_pkg::FadeWidth-1:0] fade, logic gray);
      logic [plt_pkg::PackedWidth-1:0] noise;
      noise = plt_pkg::PackedWidth'({$urandom, $urandom});
      write_csr(plt_pkg::CsrAmbientAdd, add);
      write_csr(plt_pkg::CsrAmbientScale, scale);
      write_csr(plt_pkg::CsrLightColor, light);
      write_csr(plt_pkg::CsrFadeAmount,
                {noise[plt_pkg::PackedWidth-1:plt_pkg::FadeWidth], fade});
      write_csr(plt_pkg::CsrGrayEnable, {noise[plt_pkg::PackedWidth-1:1], gray});
   endtask

   function automatic logic [plt_pkg::LaneWidth-1:0] random_lane();
      case ($urandom_range(3))
         0:       return plt_pkg::LaneWidth'($urandom);
         1:       return plt_pkg::LaneWidth'(int'($urandom_range(2 * Unity)) - Unity);
         default: return plt_pkg::LaneWidth'($urandom_range(2 * Unity));
      endcase
   endfunction

   function automatic logic [plt_pkg::PackedWidth-1:0] random_triple();
      return {random_lane(), random_lane(), random_lane()};
   endfunction

   task automatic write_random_config();
      logic [plt_pkg::FadeWidth-1:0] fade;
      fade = ($urandom_range(3) == 0) ? plt_pkg::FadeWidth'($urandom)
                                      : plt_pkg::FadeWidth'($urandom_range(2 * Unity));
      write_config(random_triple(), random_triple(), random_triple(), fade, 1'($urandom));
   endtask

   task automatic queue_color(int r, g, b, index);
      palette_color_type c;
      c.red   = plt_pkg::ColorWidth'(r);
      c.green = plt_pkg::ColorWidth'(g);
      c.blue  = plt_pkg::ColorWidth'(b);
      c.index = plt_pkg::ColorWidth'(index);
      color_items.push_back(c);
   endtask

   task automatic queue_random_colors(int count);
      @(posedge clock);
      repeat (count) queue_color($urandom_range(255), $urandom_range(255),
                                 $urandom_range(255), $urandom_range(255));
   endtask

   task automatic wait_drained();
      while (color_items.size() != 0 || accepted_n != offered_n || words_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings; white input gives exactly one on the lit words
      @(posedge clock);
      queue_color(0, 0, 0, 0);
      queue_color(255, 255, 255, 255);
      queue_color(255, 0, 0, 1);
      queue_color(0, 255, 0, 2);
      queue_color(0, 0, 255, 3);
      queue_color(1, 128, 254, 4);
      queue_color(170, 85, 15, 16);
      queue_color(85, 170, 240, 200);
      wait_drained();

      // all maxima, grayscale on
      write_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 16'hFFFF, 1'b1);
      @(posedge clock);
      queue_color(255, 255, 255, 4);
      queue_color(0, 0, 0, 5);
      queue_color(128, 200, 30, 16);
      wait_drained();

      // lane minima with unity fade: negative divisor
      write_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 16'h1000, 1'b1);
      @(posedge clock);
      queue_color(255, 0, 128, 28);
      queue_color(0, 255, 255, 255);
      wait_drained();

      // zero divisor with nonzero fade
      write_config({3{16'h0800}}, {3{16'h1000}}, {3{16'hF000}}, 16'h1000, 1'b0);
      @(posedge clock);
      queue_color(255, 128, 0, 7);
      queue_color(0, 64, 255, 99);
      wait_drained();

      // zero divisor with zero fade
      write_config({3{16'h0800}}, {3{16'h1000}}, {3{16'hF000}}, 16'h0000, 1'b0);
      @(posedge clock);
      queue_color(200, 100, 50, 4);
      queue_color(255, 255, 255, 0);
      wait_drained();

      // in-range settings; writes to unused indexes must not land anywhere
      write_config('0, {3{16'h1000}}, {16'h0400, 16'h0200, 16'h0000}, 16'h1000, 1'b0);
      write_csr(CsrFirstUnused, plt_pkg::PackedWidth'({$urandom, $urandom}));
      write_csr(CsrLastUnused, plt_pkg::PackedWidth'({$urandom, $urandom}));
      @(posedge clock);
      queue_color(255, 255, 255, 9);
      queue_color(3, 7, 250, 40);
      wait_drained();

      for (int p = 0; p < RandomPhases; p++) begin
         write_random_config();
         @(posedge clock);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin sender_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         if (p == 2) hold_arm = 1'b1;
         queue_random_colors(PhaseItems / 2);
         wait_drained();
         queue_random_colors(PhaseItems - PhaseItems / 2);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && words_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
